// ===== sv/lsgmd_pkg.sv =====
// Package for the lidar scan gate and min-pool decimator.
// Holds widths, register indexes, reset values and the front-to-back command word.
// No dependencies.
`default_nettype none

package lsgmd_pkg;

  // Largest pooling factor the storage is built for.
  localparam int MAX_FACTOR  = 8;
  localparam int EARLY_DEPTH = MAX_FACTOR - 1;
  localparam int EARLY_IDX_W = (EARLY_DEPTH > 1) ? $clog2(EARLY_DEPTH) : 1;
  localparam int CNT_W       = $clog2(MAX_FACTOR + 1);

  // Fixed field widths.
  localparam int RANGE_W    = 16;
  localparam int MRAD_W     = 13;
  localparam int FACTOR_W   = 4;
  localparam int FAC_W      = (CNT_W > FACTOR_W) ? CNT_W : FACTOR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Command queue between the front and the back part.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef logic [RANGE_W-1:0]        range_t;
  typedef logic signed [MRAD_W-1:0]  mrad_t;
  typedef logic [FACTOR_W-1:0]       factor_t;
  typedef logic [FAC_W-1:0]          fac_t;
  typedef logic [EARLY_IDX_W-1:0]    early_idx_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_MIN  = 3'd0,
    CFG_WINDOW_MAX  = 3'd1,
    CFG_GATE_MIN    = 3'd2,
    CFG_POOLED_MAX  = 3'd3,
    CFG_FULL_MAX    = 3'd4,
    CFG_POOL_FACTOR = 3'd5
  } cfg_idx_t;

  // Register reset values.
  localparam mrad_t   RST_WINDOW_MIN  = -13'sd3142;
  localparam mrad_t   RST_WINDOW_MAX  = 13'sd3142;
  localparam range_t  RST_GATE_MIN    = 16'd50;
  localparam range_t  RST_POOLED_MAX  = 16'd64000;
  localparam range_t  RST_FULL_MAX    = 16'd64000;
  localparam factor_t RST_POOL_FACTOR = 4'd2;

  // One stored early bin: valid flag above the (already zeroed) range.
  typedef struct packed {
    logic   valid;
    range_t range;
  } early_bin_t;

  // Work for the back part caused by one accepted word.
  typedef struct packed {
    logic       has_c0;
    logic       c0_valid;
    range_t     c0_range;
    logic       has_c1;
    logic       c1_valid;
    range_t     c1_range;
    logic       wr_en;
    early_idx_t wr_idx;
    early_bin_t wr_data;
    fac_t       flush_n;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/lsgmd_if.sv =====
// Channel interfaces for the lidar scan gate and min-pool decimator.
// Depends on lsgmd_pkg for the field types.
`default_nettype none

interface lsgmd_in_if;
  logic                   valid;
  logic                   ready;
  lsgmd_pkg::range_t      range_mm;
  logic                   range_finite;
  lsgmd_pkg::mrad_t       bin_angle_mrad;
  lsgmd_pkg::mrad_t       scan_end_angle_mrad;
  lsgmd_pkg::range_t      sensor_min_mm;
  lsgmd_pkg::range_t      sensor_max_mm;
  logic                   scan_last;

  modport source (
    output valid, range_mm, range_finite, bin_angle_mrad, scan_end_angle_mrad,
           sensor_min_mm, sensor_max_mm, scan_last,
    input  ready
  );
  modport sink (
    input  valid, range_mm, range_finite, bin_angle_mrad, scan_end_angle_mrad,
           sensor_min_mm, sensor_max_mm, scan_last,
    output ready
  );
endinterface

interface lsgmd_out_if;
  logic              valid;
  logic              ready;
  logic              channel;
  lsgmd_pkg::range_t result_range_mm;
  logic              result_valid;
  logic              run_last;

  modport source (
    output valid, channel, result_range_mm, result_valid, run_last,
    input  ready
  );
  modport sink (
    input  valid, channel, result_range_mm, result_valid, run_last,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/lsgmd_front.sv =====
// Front part: configuration registers, window test, range gating and pooling state.
// Turns each accepted word in the window, or one ending a short scan, into a command
// for the back part. Depends on lsgmd_pkg and lsgmd_if.
`default_nettype none

module lsgmd_front (
  input  logic               clk,
  input  logic               rst_n,
  lsgmd_in_if.sink           in_bin,
  input  logic               cfg_we,
  input  logic [lsgmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsgmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic               q_ready,
  output logic               q_push,
  output lsgmd_pkg::cmd_t    q_data
);

  // Configuration registers.
  lsgmd_pkg::mrad_t   win_min_r, win_max_r;
  lsgmd_pkg::range_t  gate_min_r, pooled_max_r, full_max_r;
  lsgmd_pkg::factor_t pool_factor_r;

  // Scan state.
  lsgmd_pkg::range_t  group_min_r, group_min_nxt;
  logic               group_has_r, group_has_nxt;
  lsgmd_pkg::fac_t    group_fill_r, group_fill_nxt;
  lsgmd_pkg::fac_t    seen_r, seen_nxt;

  // Decoded settings.
  lsgmd_pkg::mrad_t   wlo, whi, top;
  lsgmd_pkg::range_t  gmin, pmax, fmax, lo, hi_f, hi_p;
  lsgmd_pkg::fac_t    fac;
  logic               fac_one;

  logic               accept, in_win, vf, vp, complete;
  lsgmd_pkg::fac_t    fill_inc, flush_n;
  logic               min_take;
  lsgmd_pkg::range_t  r;

  assign r      = in_bin.range_mm;
  assign accept = in_bin.valid && in_bin.ready;
  assign in_bin.ready = q_ready;

  // Settings: swap reversed limits, replace a full limit below the gate minimum, and clamp the factor.
  always_comb begin
    if (win_max_r < win_min_r) begin
      wlo = win_max_r;
      whi = win_min_r;
    end else begin
      wlo = win_min_r;
      whi = win_max_r;
    end
    if (pooled_max_r < gate_min_r) begin
      gmin = pooled_max_r;
      pmax = gate_min_r;
    end else begin
      gmin = gate_min_r;
      pmax = pooled_max_r;
    end
    fmax = (full_max_r < gmin) ? pmax : full_max_r;
    if (pool_factor_r == '0) begin
      fac = lsgmd_pkg::fac_t'(1);
    end else if (lsgmd_pkg::fac_t'(pool_factor_r) >
                 lsgmd_pkg::fac_t'(lsgmd_pkg::MAX_FACTOR)) begin
      fac = lsgmd_pkg::fac_t'(lsgmd_pkg::MAX_FACTOR);
    end else begin
      fac = lsgmd_pkg::fac_t'(pool_factor_r);
    end
    fac_one = (fac == lsgmd_pkg::fac_t'(1));
  end

  // Window test and the two range gates.
  always_comb begin
    top  = (whi < in_bin.scan_end_angle_mrad) ? whi : in_bin.scan_end_angle_mrad;
    lo   = (gmin > in_bin.sensor_min_mm) ? gmin : in_bin.sensor_min_mm;
    hi_f = (in_bin.sensor_max_mm != '0 && in_bin.sensor_max_mm < fmax) ?
           in_bin.sensor_max_mm : fmax;
    hi_p = (in_bin.sensor_max_mm != '0 && in_bin.sensor_max_mm < pmax) ?
           in_bin.sensor_max_mm : pmax;
    in_win = (in_bin.bin_angle_mrad >= wlo) && (in_bin.bin_angle_mrad <= top);
    vf = in_bin.range_finite && (r >= lo) && (r <= hi_f);
    vp = in_bin.range_finite && (r >= lo) && (r <= hi_p);
  end

  // Pooling update and command build.
  always_comb begin
    group_min_nxt  = group_min_r;
    group_has_nxt  = group_has_r;
    group_fill_nxt = group_fill_r;
    seen_nxt       = seen_r;
    complete       = 1'b0;
    min_take       = 1'b0;
    fill_inc       = group_fill_r + lsgmd_pkg::fac_t'(1);
    flush_n        = '0;

    q_data          = '0;
    q_data.has_c0   = in_win;
    q_data.c0_valid = vf;
    q_data.c0_range = vf ? r : '0;
    q_data.wr_idx   = seen_r[lsgmd_pkg::EARLY_IDX_W-1:0];
    q_data.wr_data  = '{valid: vp, range: (vp ? r : '0)};

    if (in_win && fac_one) begin
      q_data.has_c1   = 1'b1;
      q_data.c1_valid = vp;
      q_data.c1_range = vp ? r : '0;
    end else if (in_win) begin
      q_data.wr_en = (seen_r < lsgmd_pkg::fac_t'(lsgmd_pkg::EARLY_DEPTH));
      if (seen_r < fac) begin
        seen_nxt = seen_r + lsgmd_pkg::fac_t'(1);
      end
      min_take = vp && (!group_has_r || r < group_min_r);
      if (min_take) begin
        group_min_nxt = r;
        group_has_nxt = 1'b1;
      end
      complete = (fill_inc >= fac);
      // A full group goes out and the accumulator starts again.
      if (complete) begin
        q_data.has_c1   = 1'b1;
        q_data.c1_valid = group_has_nxt;
        q_data.c1_range = group_has_nxt ? group_min_nxt : '0;
        group_min_nxt   = '1;
        group_has_nxt   = 1'b0;
        group_fill_nxt  = '0;
      end else begin
        group_fill_nxt  = fill_inc;
      end
    end

    // Scan end: a short scan is replayed unpooled, then all scan state clears.
    if (in_bin.scan_last) begin
      if (!fac_one && seen_nxt < fac) begin
        flush_n = seen_nxt;
      end
      group_min_nxt  = '1;
      group_has_nxt  = 1'b0;
      group_fill_nxt = '0;
      seen_nxt       = '0;
    end
    q_data.flush_n = flush_n;
  end

  assign q_push = accept && (in_win || flush_n != '0);

  // Configuration and scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_min_r     <= lsgmd_pkg::RST_WINDOW_MIN;
      win_max_r     <= lsgmd_pkg::RST_WINDOW_MAX;
      gate_min_r    <= lsgmd_pkg::RST_GATE_MIN;
      pooled_max_r  <= lsgmd_pkg::RST_POOLED_MAX;
      full_max_r    <= lsgmd_pkg::RST_FULL_MAX;
      pool_factor_r <= lsgmd_pkg::RST_POOL_FACTOR;
      group_min_r   <= '1;
      group_has_r   <= 1'b0;
      group_fill_r  <= '0;
      seen_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (lsgmd_pkg::cfg_idx_t'(cfg_index))
          lsgmd_pkg::CFG_WINDOW_MIN:  win_min_r    <= lsgmd_pkg::mrad_t'(cfg_wdata[12:0]);
          lsgmd_pkg::CFG_WINDOW_MAX:  win_max_r    <= lsgmd_pkg::mrad_t'(cfg_wdata[12:0]);
          lsgmd_pkg::CFG_GATE_MIN:    gate_min_r   <= cfg_wdata;
          lsgmd_pkg::CFG_POOLED_MAX:  pooled_max_r <= cfg_wdata;
          lsgmd_pkg::CFG_FULL_MAX:    full_max_r   <= cfg_wdata;
          lsgmd_pkg::CFG_POOL_FACTOR: pool_factor_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        group_min_r  <= group_min_nxt;
        group_has_r  <= group_has_nxt;
        group_fill_r <= group_fill_nxt;
        seen_r       <= seen_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lsgmd_cmdq.sv =====
// Short command queue between the front and the back part.
// Depends on lsgmd_pkg for the command word and the depth.
`default_nettype none

module lsgmd_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lsgmd_pkg::cmd_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output lsgmd_pkg::cmd_t pop_data
);

  lsgmd_pkg::cmd_t                     slot_r [lsgmd_pkg::CMDQ_DEPTH];
  logic [lsgmd_pkg::CMDQ_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [lsgmd_pkg::CMDQ_CNT_W-1:0]    count_r;
  logic                                do_push, do_pop;

  assign push_ready = (count_r != lsgmd_pkg::CMDQ_CNT_W'(lsgmd_pkg::CMDQ_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == lsgmd_pkg::CMDQ_PTR_W'(lsgmd_pkg::CMDQ_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == lsgmd_pkg::CMDQ_PTR_W'(lsgmd_pkg::CMDQ_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lsgmd_back.sv =====
// Back part: steps through each command and drives the result words.
// Holds the early-bin store for the short-scan replay. Depends on lsgmd_pkg and lsgmd_if.
`default_nettype none

module lsgmd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  lsgmd_pkg::cmd_t q_data,
  output logic            q_pop,
  lsgmd_out_if.source     out_res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_C0,
    S_C1,
    S_FL
  } state_t;

  state_t                  state_r, state_nxt, adv;
  lsgmd_pkg::cmd_t         cmd_r;
  lsgmd_pkg::fac_t         fl_idx_r;
  lsgmd_pkg::early_bin_t   early_mem [lsgmd_pkg::EARLY_DEPTH];

  logic                    out_valid_r, out_channel_r, out_rvalid_r, out_last_r;
  lsgmd_pkg::range_t       out_range_r;

  logic                    load_ok, emit, cmd_end;
  logic                    res_ch, res_valid;
  lsgmd_pkg::range_t       res_range;

  function automatic state_t first_state(lsgmd_pkg::cmd_t c);
    if (c.has_c0) begin
      return S_C0;
    end else if (c.has_c1) begin
      return S_C1;
    end else begin
      return S_FL;
    end
  endfunction

  assign out_res.valid           = out_valid_r;
  assign out_res.channel         = out_channel_r;
  assign out_res.result_range_mm = out_range_r;
  assign out_res.result_valid    = out_rvalid_r;
  assign out_res.run_last        = out_last_r;

  // Sequencing: one result word per cycle while the output register is free.
  always_comb begin
    load_ok   = !out_valid_r || out_res.ready;
    emit      = load_ok && (state_r != S_IDLE);
    res_ch    = 1'b1;
    res_valid = cmd_r.c1_valid;
    res_range = cmd_r.c1_range;
    unique case (state_r)
      S_IDLE: begin
        adv = S_IDLE;
      end
      S_C0: begin
        res_ch    = 1'b0;
        res_valid = cmd_r.c0_valid;
        res_range = cmd_r.c0_range;
        if (cmd_r.has_c1) begin
          adv = S_C1;
        end else begin
          adv = (cmd_r.flush_n != '0) ? S_FL : S_IDLE;
        end
      end
      S_C1: begin
        adv = (cmd_r.flush_n != '0) ? S_FL : S_IDLE;
      end
      S_FL: begin
        adv = ((fl_idx_r + lsgmd_pkg::fac_t'(1)) < cmd_r.flush_n) ? S_FL : S_IDLE;
      end
      default: begin
        adv = S_IDLE;
      end
    endcase
    cmd_end = emit && (adv == S_IDLE);
    q_pop   = q_valid && ((state_r == S_IDLE) || cmd_end);
    if (q_pop) begin
      state_nxt = first_state(q_data);
    end else if (emit) begin
      state_nxt = adv;
    end else begin
      state_nxt = state_r;
    end
  end

  // State and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fl_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        cmd_r    <= q_data;
        fl_idx_r <= '0;
      end else if (emit && state_r == S_FL) begin
        fl_idx_r <= fl_idx_r + lsgmd_pkg::fac_t'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        out_last_r  <= (adv == S_IDLE);
        if (state_r == S_FL) begin
          out_channel_r <= 1'b1;
          out_rvalid_r  <= early_mem[fl_idx_r[lsgmd_pkg::EARLY_IDX_W-1:0]].valid;
          out_range_r   <= early_mem[fl_idx_r[lsgmd_pkg::EARLY_IDX_W-1:0]].range;
        end else begin
          out_channel_r <= res_ch;
          out_rvalid_r  <= res_valid;
          out_range_r   <= res_range;
        end
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Early-bin store, written as each command is taken so it stays in order.
  always_ff @(posedge clk) begin
    if (q_pop && q_data.wr_en) begin
      early_mem[q_data.wr_idx] <= q_data.wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lidar_scan_gate_min_decimator_unit.sv =====
// Top level of the lidar scan gate and min-pool decimator.
// Instantiates lsgmd_front, lsgmd_cmdq and lsgmd_back; depends on lsgmd_pkg and lsgmd_if.
//
//   Port      | Direction | Word
//   ----------+-----------+---------------------------------------------------
//   in_bin    | sink      | one lidar bin with its scan and sensor limits
//   out_res   | source    | one result: channel, range, valid flag, run end
//   cfg_*     | sink      | register write: enable, index, data (no read-back)
//
// The front takes one word per cycle whenever the two-entry command queue has room.
// The back drives one result word per cycle while the output register is free: a bin in
// the window gives a channel-0 word, plus a channel-1 word with factor one or a completed
// group, and a short-scan replay gives one channel-1 word per stored bin (up to seven).
// A new command is taken as the last result of the previous one is loaded, so the back
// goes straight on to it. Reset is synchronous, active low; no clearing pass is needed.
`default_nettype none

module lidar_scan_gate_min_decimator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  lsgmd_in_if.sink                            in_bin,
  lsgmd_out_if.source                         out_res,
  input  logic                                cfg_we,
  input  logic [lsgmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsgmd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic            push, push_ready, pop, pop_valid;
  lsgmd_pkg::cmd_t push_data, pop_data;

  // Accept, classify and pool.
  lsgmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bin    (in_bin),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_ready   (push_ready),
    .q_push    (push),
    .q_data    (push_data)
  );

  // Command queue.
  lsgmd_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // Result sequencing.
  lsgmd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .out_res (out_res)
  );

endmodule

`default_nettype wire
